// File: src/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg: shared definitions for the greedy coin change block
// Widths, register indexes, reset values and the cell control bundle.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int DATA_W            = 16;
    localparam int COIN_REGS         = 4;
    localparam int MAX_DENOMINATIONS = 4;
    // one divider cell per denomination that can be taken into account
    localparam int NUM_CELLS = (MAX_DENOMINATIONS < COIN_REGS) ? MAX_DENOMINATIONS
                                                                : COIN_REGS;
    localparam int PTR_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int STEP_W    = $clog2(DATA_W);
    localparam int CFG_IDX_W = 3;
    localparam int USE_W     = 3;
    localparam int M_TDATA_W = 3 * DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COINS_IN_USE = 3'd4;

    localparam logic [DATA_W-1:0] RST_COIN_VALUE_A = 16'd11;
    localparam logic [DATA_W-1:0] RST_COIN_VALUE_B = 16'd5;
    localparam logic [DATA_W-1:0] RST_COIN_VALUE_C = 16'd1;
    localparam logic [DATA_W-1:0] RST_COIN_VALUE_D = 16'd0;
    localparam logic [USE_W-1:0]  RST_COINS_IN_USE = 3'd3;

    typedef struct packed {
        logic start;  // load dividend, begin a division
        logic en;     // denomination in use and nonzero
    } cell_ctl_t;

endpackage

// File: src/gcc_cell.sv
// ----------------------------------------------------------------------------
// gcc_cell: one denomination stage of the coin change chain
// Bit-serial restoring divider, one quotient bit per cycle. A disabled cell
// never subtracts, so it returns a zero count and passes the dividend on.
// ----------------------------------------------------------------------------
module gcc_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gcc_pkg::cell_ctl_t        ctl,
    input  logic [gcc_pkg::DATA_W-1:0] dividend,
    input  logic [gcc_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [gcc_pkg::DATA_W-1:0] quotient,
    output logic [gcc_pkg::DATA_W-1:0] remainder
);
    import gcc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] num_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    always_comb begin
        shifted = {rem_reg, num_reg[DATA_W-1]};
        diff    = shifted - {1'b0, divisor};
        fits    = ctl.en && (shifted >= {1'b0, divisor});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && !ctl.start && (step_reg == STEP_W'(DATA_W - 1));
            if (ctl.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DATA_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: src/greedy_coin_change.sv
// ----------------------------------------------------------------------------
// greedy_coin_change: greedy split of an amount into coins
// A chain of divider cells, one per denomination, hands the unpaid rest from
// cell to cell; a scan then sends one item per denomination that gives coins, or a single zero item when none does.
// ----------------------------------------------------------------------------
//  channel  | ports                        | content
//  ---------+------------------------------+-----------------------------------
//  input    | s_tvalid s_tready s_tdata    | amount
//  result   | m_tvalid m_tready m_tdata    | denomination, coin_count, leftover
//           | m_tlast                      | last_result
//  config   | cfg_valid cfg_ready          | cfg_index, cfg_data
//
//  Each cell runs 16 shift steps and then hands the rest on to the next
//  cell; the scan starts in the cycle after the last cell finishes and walks
//  the cells up to the last result, held while a result waits and m_tready
//  is low. One item is in work at a time; a new item is taken while the
//  final result still waits in the output register.
//  Reset loads the register defaults and empties the block.
// ----------------------------------------------------------------------------
module greedy_coin_change (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gcc_pkg::DATA_W-1:0]        s_tdata,   // [15:0] amount
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] denomination, [31:16] coin_count, [47:32] leftover
    output logic [gcc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,   // last_result
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcc_pkg::DATA_W-1:0]        cfg_data
);
    import gcc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_EMIT} state_t;

    state_t            state_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] out_denom_reg;
    logic [DATA_W-1:0] out_count_reg;
    logic [DATA_W-1:0] out_left_reg;
    logic              out_last_reg;

    logic [DATA_W-1:0] coin_reg [COIN_REGS];
    logic [USE_W-1:0]  coins_in_use_reg;

    cell_ctl_t         cell_ctl  [NUM_CELLS];
    logic [DATA_W-1:0] cell_div  [NUM_CELLS];
    logic [DATA_W-1:0] cell_quo  [NUM_CELLS];
    logic [DATA_W-1:0] cell_rem  [NUM_CELLS];
    logic [DATA_W-1:0] cell_coin [NUM_CELLS];
    logic [NUM_CELLS-1:0] cell_done;
    logic [NUM_CELLS-1:0] used;
    logic [NUM_CELLS-1:0] last_at;

    logic accept;
    logic out_free;
    logic emit;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = (state_reg == ST_EMIT) && out_free && ((used == '0) || used[ptr_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coin_reg[0]      <= RST_COIN_VALUE_A;
            coin_reg[1]      <= RST_COIN_VALUE_B;
            coin_reg[2]      <= RST_COIN_VALUE_C;
            coin_reg[3]      <= RST_COIN_VALUE_D;
            coins_in_use_reg <= RST_COINS_IN_USE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COIN_VALUE_A: coin_reg[0]      <= cfg_data;
                REG_COIN_VALUE_B: coin_reg[1]      <= cfg_data;
                REG_COIN_VALUE_C: coin_reg[2]      <= cfg_data;
                REG_COIN_VALUE_D: coin_reg[3]      <= cfg_data;
                REG_COINS_IN_USE: coins_in_use_reg <= cfg_data[USE_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        assign cell_coin[i]    = coin_reg[i];
        assign cell_ctl[i].en  = (coins_in_use_reg > USE_W'(i)) && (coin_reg[i] != '0);
        if (i == 0) begin : g_head
            assign cell_ctl[i].start = accept;
            assign cell_div[i]       = s_tdata;
        end else begin : g_link
            assign cell_ctl[i].start = cell_done[i-1];
            assign cell_div[i]       = cell_rem[i-1];
        end
        assign used[i] = (cell_quo[i] != '0);

        gcc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (cell_ctl[i]),
            .dividend  (cell_div[i]),
            .divisor   (cell_coin[i]),
            .done      (cell_done[i]),
            .quotient  (cell_quo[i]),
            .remainder (cell_rem[i])
        );
    end

    // a used cell is last when no later cell gives coins
    always_comb begin
        for (int k = 0; k < NUM_CELLS; k++) begin
            last_at[k] = 1'b1;
            for (int j = k + 1; j < NUM_CELLS; j++) begin
                if (used[j]) begin
                    last_at[k] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !emit) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (cell_done[NUM_CELLS-1]) begin
                        state_reg <= ST_EMIT;
                        ptr_reg   <= '0;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        priority if (used == '0) begin
                            // nothing paid: one zero item carrying the whole amount
                            m_tvalid_reg  <= 1'b1;
                            out_denom_reg <= '0;
                            out_count_reg <= '0;
                            out_left_reg  <= cell_rem[NUM_CELLS-1];
                            out_last_reg  <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end else if (used[ptr_reg]) begin
                            m_tvalid_reg  <= 1'b1;
                            out_denom_reg <= cell_coin[ptr_reg];
                            out_count_reg <= cell_quo[ptr_reg];
                            out_left_reg  <= last_at[ptr_reg] ? cell_rem[NUM_CELLS-1] : '0;
                            out_last_reg  <= last_at[ptr_reg];
                            if (last_at[ptr_reg]) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                ptr_reg <= ptr_reg + 1'b1;
                            end
                        end else begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_left_reg, out_count_reg, out_denom_reg};
    assign m_tlast  = out_last_reg;

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_done != '0) |-> (state_reg == ST_DIVIDE))
        else $error("cell finished outside the divide phase");

    a_one_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_done))
        else $error("more than one cell finished at once");

    a_zero_count_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2*DATA_W-1:DATA_W] == '0))
            |-> (m_tlast && (m_tdata[DATA_W-1:0] == '0)))
        else $error("zero-count item that is not the nothing-paid item");

    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DIVIDE) && (cell_done == '0))
        else $error("divide phase not entered after accepting an item");

endmodule

// File: sim/coin_change_checker.sv
// ----------------------------------------------------------------------------
// coin_change_checker: result checker for the greedy coin change block
// Tracks the denomination registers from the config channel, works out the
// coin split of every accepted amount and compares each result item with the
// oldest one still expected, field by field.
// ----------------------------------------------------------------------------
module coin_change_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [gcc_pkg::DATA_W-1:0]     s_tdata,    // [15:0] amount
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] denomination, [31:16] coin_count, [47:32] leftover
    input  logic [gcc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,    // last_result
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [gcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcc_pkg::DATA_W-1:0]     cfg_data,
    output int                             fail_count,
    output int                             pending_count,
    output int                             amounts_seen,
    output int                             results_seen,
    output int                             unpaid_seen
);
    import gcc_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] denomination;
        logic [DATA_W-1:0] coin_count;
        logic [DATA_W-1:0] leftover;
        logic              last_result;
    } coin_result_t;

    coin_result_t      expected_coins[$];
    logic [DATA_W-1:0] coin_value[COIN_REGS];
    logic [USE_W-1:0]  coins_used;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        amounts_seen  = 0;
        results_seen  = 0;
        unpaid_seen   = 0;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    // Greedy split: one item per denomination that pays, the last one carries
    // the unpaid rest; an empty split gives a single zero item.
    task automatic predict_change(input logic [DATA_W-1:0] amount);
        int unsigned  rest;
        int unsigned  limit;
        int unsigned  coin;
        int unsigned  count;
        int           idx;
        bit           have_item;
        coin_result_t held;
        rest      = amount;
        limit     = coins_used;
        have_item = 1'b0;
        held      = '0;
        if (limit > MAX_DENOMINATIONS) limit = MAX_DENOMINATIONS;
        if (limit > COIN_REGS) limit = COIN_REGS;
        for (idx = 0; idx < limit && rest != 0; idx++) begin
            coin = coin_value[idx];
            if (coin != 0) begin
                count = rest / coin;
                if (count != 0) begin
                    if (have_item) expected_coins.insert(expected_coins.size(), held);
                    rest               = rest - count * coin;
                    held.denomination  = coin[DATA_W-1:0];
                    held.coin_count    = count[DATA_W-1:0];
                    held.leftover      = '0;
                    held.last_result   = 1'b0;
                    have_item          = 1'b1;
                end
            end
        end
        held.leftover    = rest[DATA_W-1:0];
        held.last_result = 1'b1;
        expected_coins.insert(expected_coins.size(), held);
    endtask

    task automatic check_result(input coin_result_t got);
        coin_result_t want;
        results_seen++;
        if (expected_coins.size() == 0) begin
            report_mismatch("item with no amount pending, denomination", '0,
                            got.denomination);
        end else begin
            want = expected_coins.pop_front();
            if (got.denomination !== want.denomination)
                report_mismatch("denomination", want.denomination, got.denomination);
            if (got.coin_count !== want.coin_count)
                report_mismatch("coin_count", want.coin_count, got.coin_count);
            if (got.leftover !== want.leftover)
                report_mismatch("leftover", want.leftover, got.leftover);
            if (got.last_result !== want.last_result)
                report_mismatch("last_result", {15'd0, want.last_result},
                                {15'd0, got.last_result});
            if (want.last_result && want.leftover != 0) unpaid_seen++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            coin_value[0] = RST_COIN_VALUE_A;
            coin_value[1] = RST_COIN_VALUE_B;
            coin_value[2] = RST_COIN_VALUE_C;
            coin_value[3] = RST_COIN_VALUE_D;
            coins_used    = RST_COINS_IN_USE;
            expected_coins.delete();
        end else begin
            // compare before predicting so a fresh amount never meets its own slot
            if (m_tvalid && m_tready)
                check_result({m_tdata[DATA_W-1:0], m_tdata[2*DATA_W-1:DATA_W],
                              m_tdata[3*DATA_W-1:2*DATA_W], m_tlast});
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < COIN_REGS)
                    coin_value[int'(cfg_index)] = cfg_data;
                else if (cfg_index == REG_COINS_IN_USE)
                    coins_used = cfg_data[USE_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                predict_change(s_tdata);
                amounts_seen++;
            end
        end
        pending_count = expected_coins.size();
    end

endmodule

// File: sim/greedy_coin_change_tb.sv
// ----------------------------------------------------------------------------
// greedy_coin_change_tb: testbench top for the greedy coin change block
// Drives amounts and register writes with random gaps and receiver stalls,
// runs directed corner cases and then random coin sets, and leaves all
// checking to the checker module beside the block.
// ----------------------------------------------------------------------------
module greedy_coin_change_tb;
    import gcc_pkg::*;

    localparam int CLOCK_LIMIT   = 600000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = DATA_W * NUM_CELLS + 2 * NUM_CELLS + 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 45;
    localparam int TOP_INDEX     = (1 << CFG_IDX_W) - 1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;     // [15:0] amount
    logic                 m_tvalid;
    logic                 m_tready;
    // [15:0] denomination, [31:16] coin_count, [47:32] leftover
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;     // last_result
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    int fail_count;
    int pending_count;
    int amounts_seen;
    int results_seen;
    int unpaid_seen;
    int cycle_count;
    int setting_count;

    logic              quiet_tail;
    logic              long_hold_req;
    logic [DATA_W-1:0] cur_coin[COIN_REGS];

    greedy_coin_change dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    coin_change_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .amounts_seen  (amounts_seen),
        .results_seen  (results_seen),
        .unpaid_seen   (unpaid_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CLOCK_LIMIT) begin
                $display("timeout after %0d cycles, %0d items still expected",
                         cycle_count, pending_count);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, one long hold on request, none at the tail.
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold_req && !hold_taken) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_taken = 1'b1;
                m_tready   = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // All driver tasks start and end on a falling edge.
    task automatic send_amount(input logic [DATA_W-1:0] amount);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = amount;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sender until every expected item has come back.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic setup_coins(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                               input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] d,
                               input logic [DATA_W-1:0] use_data);
        drain_results();
        write_reg(REG_COIN_VALUE_A, a);
        write_reg(REG_COIN_VALUE_B, b);
        write_reg(REG_COIN_VALUE_C, c);
        write_reg(REG_COIN_VALUE_D, d);
        write_reg(REG_COINS_IN_USE, use_data);
        cur_coin[0] = a;
        cur_coin[1] = b;
        cur_coin[2] = c;
        cur_coin[3] = d;
        setting_count++;
    endtask

    function automatic logic [DATA_W-1:0] pick_coin(input int mode, input int unsigned ceiling);
        int unsigned v;
        case (mode)
            0: v = $urandom_range(1, ceiling);
            1: v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, ceiling);
            2: case ($urandom_range(0, 3))
                   0: v = 0;
                   1: v = 1;
                   2: v = 65535;
                   default: v = $urandom_range(0, 65535);
               endcase
            default: v = $urandom_range(0, 65535);
        endcase
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick_amount();
        int unsigned v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 200);
            1: v = cur_coin[$urandom_range(0, COIN_REGS - 1)] * $urandom_range(0, 30)
                   + $urandom_range(0, 3);
            2: case ($urandom_range(0, 3))
                   0: v = 0;
                   1: v = 1;
                   2: v = 65534;
                   default: v = 65535;
               endcase
            default: v = $urandom();
        endcase
        return v[DATA_W-1:0];
    endfunction

    initial begin
        logic [DATA_W-1:0] coin_a;
        logic [DATA_W-1:0] coin_b;
        logic [DATA_W-1:0] coin_c;
        logic [DATA_W-1:0] coin_d;
        logic [DATA_W-1:0] use_data;
        int                mode;
        int                idx;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        quiet_tail    = 1'b0;
        long_hold_req = 1'b0;
        setting_count = 1;
        cur_coin[0]   = RST_COIN_VALUE_A;
        cur_coin[1]   = RST_COIN_VALUE_B;
        cur_coin[2]   = RST_COIN_VALUE_C;
        cur_coin[3]   = RST_COIN_VALUE_D;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset coin set, zero amount pays nothing
        send_amount(16'd0);
        send_amount(16'd1);
        send_amount(16'd5);
        send_amount(16'd11);
        send_amount(16'd16);
        send_amount(16'd65535);
        send_amount(16'hAAAA);
        send_amount(16'h5555);

        // zero denomination in the middle, count register above the cell count
        setup_coins(16'd65535, 16'd0, 16'd1, 16'd3, 16'hFFFF);
        for (idx = REG_COINS_IN_USE + 1; idx <= TOP_INDEX; idx++)
            write_reg(idx[CFG_IDX_W-1:0], DATA_W'($urandom_range(0, 65535)));
        send_amount(16'd65535);
        send_amount(16'd65534);
        send_amount(16'd2);

        // unpaid rest, nothing-paid with a nonzero amount
        setup_coins(16'd7, 16'd3, 16'd0, 16'd0, 16'd2);
        send_amount(16'd11);
        send_amount(16'd2);
        send_amount(16'd6);
        send_amount(16'd13);

        // count register zero
        setup_coins(16'd11, 16'd5, 16'd1, 16'd0, 16'h0008);
        send_amount(16'd37);
        send_amount(16'd0);

        // every denomination zero
        setup_coins(16'd0, 16'd0, 16'd0, 16'd0, 16'd4);
        send_amount(16'd100);

        // unsorted register order, last register pays
        setup_coins(16'd40000, 16'd7, 16'd65535, 16'd5, 16'd4);
        send_amount(16'd65535);

        // all four denominations give coins
        setup_coins(16'd1000, 16'd100, 16'd10, 16'd1, 16'd4);
        send_amount(16'd65535);
        send_amount(16'd1234);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            mode = $urandom_range(0, 3);
            if (mode == 0) begin
                // descending set, the usual shape
                coin_a = pick_coin(0, ($urandom_range(0, 1) == 0) ? 500 : 65535);
                coin_b = pick_coin(0, coin_a);
                coin_c = pick_coin(0, coin_b);
                coin_d = ($urandom_range(0, 1) == 0) ? 16'd0 : pick_coin(0, coin_c);
            end else begin
                coin_a = pick_coin(mode, 65535);
                coin_b = pick_coin(mode, 65535);
                coin_c = pick_coin(mode, 65535);
                coin_d = pick_coin(mode, 65535);
            end
            use_data = DATA_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) != 0)
                use_data[USE_W-1:0] = USE_W'($urandom_range(2, 4));
            setup_coins(coin_a, coin_b, coin_c, coin_d, use_data);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_COINS_IN_USE + 1, TOP_INDEX)),
                          DATA_W'($urandom_range(0, 65535)));
            if (phase == 2) long_hold_req = 1'b1;
            if (phase >= RANDOM_PHASES - 2) quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_amount(pick_amount());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d amounts under %0d coin settings, %0d result items checked",
                 amounts_seen, setting_count, results_seen);
        $display("%0d splits left an unpaid rest; %0d mismatches, %0d items outstanding",
                 unpaid_seen, fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
